// ----- src/abts_pkg.sv -----
// shared types and constants of the array binary tree store
// no dependencies; used by the top level, the checker and the testbench

package abts_pkg;

  // default geometry
  localparam int NodeCount  = 128;
  localparam int ValueWidth = 32;

  // fixed field widths of the command and result beats
  localparam int OpcodeW = 3;
  localparam int IndexW  = 7;
  localparam int DataW   = 32;
  localparam int StatusW = 3;

  // a child slot of the largest index needs two more bits
  localparam int ChildW = IndexW + 2;

  // slots reachable at all: 0 up to the right child of the largest index
  localparam int MaxSlots = 2 * (2 ** IndexW - 1) + 3;

  typedef enum logic [OpcodeW-1:0] {
    OP_INS_ROOT    = 3'd0,
    OP_INS_LEFT    = 3'd1,
    OP_INS_RIGHT   = 3'd2,
    OP_REMOVE_LEAF = 3'd3,
    OP_READ_ROOT   = 3'd4,
    OP_IS_LEAF     = 3'd5,
    OP_READ_NODE   = 3'd6
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_ROOT_EXISTS  = 3'd1,
    ST_PARENT_ABSENT = 3'd2,
    ST_CHILD_EXISTS = 3'd3,
    ST_NODE_ABSENT  = 3'd4,
    ST_NOT_LEAF     = 3'd5,
    ST_TREE_EMPTY   = 3'd6,
    ST_OUT_OF_RANGE = 3'd7
  } status_e;

endpackage

// ----- src/abts_value_mem.sv -----
// node value memory: one write port, one read port, registered read data
// standalone, no package needed

module abts_value_mem #(
  parameter int Depth = 128,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/array_binary_tree_store.sv -----
// array binary tree store: top level with present bits, op decode and result register
// depends on abts_pkg and abts_value_mem

// binary tree in implicit array form: slot i has children at 2i+1 and 2i+2
// command channel: a beat is taken at a clock edge with start high and busy low;
//   opcode_i, node_index_i and node_value_i ride along with it
// busy stays low, so a command beat can be taken in every cycle
// result channel: done_o is high for exactly one cycle, in the cycle after the
//   command beat, with status_o, read_value_o, the child flags and empty_flag_o
// every op's result is registered, lined up with the registered read port of the
//   value memory; throughput: 1 beat per cycle
// present bits live in flops, the values in a one-write, one-read memory;
//   a write lands at the command edge and a read is issued at that same edge,
//   so a read in the next beat already sees it and no forwarding is needed
// only slots 0..2*127+2 can ever be addressed, so storage is capped there
// reset clears the present bits and the result strobe at once; the value
//   memory is not cleared since every read is gated by a present bit
// the receiver cannot stall: a result beat that is not taken is lost

module array_binary_tree_store #(
  parameter int NODE_COUNT  = abts_pkg::NodeCount,
  parameter int VALUE_WIDTH = abts_pkg::ValueWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [abts_pkg::OpcodeW-1:0] opcode_i,
  input  logic [abts_pkg::IndexW-1:0]  node_index_i,
  input  logic [abts_pkg::DataW-1:0]   node_value_i,
  // result channel
  output logic                         done_o,
  output logic [abts_pkg::StatusW-1:0] status_o,
  output logic [abts_pkg::DataW-1:0]   read_value_o,
  output logic                         leaf_flag_o,
  output logic                         left_present_o,
  output logic                         right_present_o,
  output logic                         empty_flag_o
);

  localparam int DataW  = abts_pkg::DataW;
  localparam int ChildW = abts_pkg::ChildW;
  // slots held: NODE_COUNT, capped at the slots that a 7-bit index can reach
  localparam int SlotCount = (NODE_COUNT < abts_pkg::MaxSlots) ? NODE_COUNT
                                                                : abts_pkg::MaxSlots;
  localparam int SlotAw = $clog2(SlotCount);
  // stored value bits: inputs are 32 bits, masked to the value width
  localparam int StoreW = (VALUE_WIDTH < DataW) ? VALUE_WIDTH : DataW;

  // a slot beyond capacity always counts as absent
  function automatic logic slot_present(logic [SlotCount-1:0] vec,
                                        logic [ChildW-1:0]    slot);
    logic hit;
    hit = 1'b0;
    if (32'(slot) < SlotCount) begin
      hit = vec[slot[SlotAw-1:0]];
    end
    return hit;
  endfunction

  logic [SlotCount-1:0] present_q;

  logic                  accept;
  abts_pkg::opcode_e     op;
  logic [ChildW-1:0]     idx_w;
  logic [ChildW-1:0]     left_slot;
  logic [ChildW-1:0]     right_slot;
  logic                  idx_in;
  logic                  idx_present;
  logic                  root_present;
  logic                  root_op;

  // per-op decisions
  abts_pkg::status_e     status_d;
  logic                  set_en;
  logic [ChildW-1:0]     set_slot;
  logic                  clr_en;
  logic                  rd_en;
  logic [ChildW-1:0]     rd_slot;

  // flags after the step
  logic                  addr_in;
  logic                  left_before;
  logic                  right_before;
  logic                  left_after;
  logic                  right_after;
  logic                  root_after;

  // result registers
  logic                  done_q;
  abts_pkg::status_e     status_q;
  logic                  rd_hit_q;
  logic                  leaf_q;
  logic                  left_q;
  logic                  right_q;
  logic                  empty_q;

  logic [StoreW-1:0]     rdata;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign op          = abts_pkg::opcode_e'(opcode_i);
  assign idx_w       = ChildW'(node_index_i);
  assign left_slot   = {1'b0, node_index_i, 1'b1};
  assign right_slot  = ChildW'({node_index_i, 1'b0}) + ChildW'(2);
  assign idx_in      = 32'(idx_w) < SlotCount;
  assign idx_present = slot_present(present_q, idx_w);
  assign root_present = present_q[0];
  assign root_op     = (op == abts_pkg::OP_INS_ROOT) || (op == abts_pkg::OP_READ_ROOT);

  // op decode: error checks in the order the ops define them
  always_comb begin
    status_d = abts_pkg::ST_OK;
    set_en   = 1'b0;
    set_slot = '0;
    clr_en   = 1'b0;
    rd_en    = 1'b0;
    rd_slot  = '0;
    case (op)
      abts_pkg::OP_INS_ROOT: begin
        if (root_present) begin
          status_d = abts_pkg::ST_ROOT_EXISTS;
        end else begin
          set_en = 1'b1;
        end
      end
      abts_pkg::OP_INS_LEFT, abts_pkg::OP_INS_RIGHT: begin
        set_slot = (op == abts_pkg::OP_INS_LEFT) ? left_slot : right_slot;
        if (!idx_in) begin
          status_d = abts_pkg::ST_OUT_OF_RANGE;
        end else if (!idx_present) begin
          status_d = abts_pkg::ST_PARENT_ABSENT;
        end else if (32'(set_slot) >= SlotCount) begin
          status_d = abts_pkg::ST_OUT_OF_RANGE;
        end else if (slot_present(present_q, set_slot)) begin
          status_d = abts_pkg::ST_CHILD_EXISTS;
        end else begin
          set_en = 1'b1;
        end
      end
      abts_pkg::OP_REMOVE_LEAF: begin
        if (!idx_in) begin
          status_d = abts_pkg::ST_OUT_OF_RANGE;
        end else if (!idx_present) begin
          status_d = abts_pkg::ST_NODE_ABSENT;
        end else if (slot_present(present_q, left_slot) ||
                     slot_present(present_q, right_slot)) begin
          status_d = abts_pkg::ST_NOT_LEAF;
        end else begin
          clr_en = 1'b1;
        end
      end
      abts_pkg::OP_READ_ROOT: begin
        if (!root_present) begin
          status_d = abts_pkg::ST_TREE_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      abts_pkg::OP_IS_LEAF: begin
        if (!idx_in) begin
          status_d = abts_pkg::ST_OUT_OF_RANGE;
        end
      end
      abts_pkg::OP_READ_NODE: begin
        rd_slot = idx_w;
        if (!idx_in) begin
          status_d = abts_pkg::ST_OUT_OF_RANGE;
        end else if (!idx_present) begin
          status_d = abts_pkg::ST_NODE_ABSENT;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        status_d = abts_pkg::ST_OUT_OF_RANGE;
      end
    endcase
  end

  // child flags of the addressed node, taken after the step: only a child
  // insert under that node can change them
  assign addr_in      = root_op | idx_in;
  assign left_before  = root_op ? slot_present(present_q, ChildW'(1))
                                : slot_present(present_q, left_slot);
  assign right_before = root_op ? slot_present(present_q, ChildW'(2))
                                : slot_present(present_q, right_slot);
  assign left_after   = left_before  | (set_en && (op == abts_pkg::OP_INS_LEFT));
  assign right_after  = right_before | (set_en && (op == abts_pkg::OP_INS_RIGHT));

  // root after the step: set by a root insert, cleared by removing slot 0
  always_comb begin
    root_after = root_present;
    if (set_en && (set_slot == '0)) begin
      root_after = 1'b1;
    end else if (clr_en && (idx_w == '0)) begin
      root_after = 1'b0;
    end
  end

  // present bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (accept) begin
      if (set_en) begin
        present_q[set_slot[SlotAw-1:0]] <= 1'b1;
      end
      if (clr_en) begin
        present_q[idx_w[SlotAw-1:0]] <= 1'b0;
      end
    end
  end

  abts_value_mem #(
    .Depth (SlotCount),
    .Width (StoreW)
  ) u_value_mem (
    .clk_i   (clk_i),
    .we_i    (accept & set_en),
    .waddr_i (set_slot[SlotAw-1:0]),
    .wdata_i (node_value_i[StoreW-1:0]),
    .re_i    (accept & rd_en),
    .raddr_i (rd_slot[SlotAw-1:0]),
    .rdata_o (rdata)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // result payload, lined up with the memory read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_hit_q <= rd_en;
      leaf_q   <= addr_in & ~left_after & ~right_after;
      left_q   <= addr_in & left_after;
      right_q  <= addr_in & right_after;
      empty_q  <= ~root_after;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_value_o    = rd_hit_q ? DataW'(rdata) : '0;
  assign leaf_flag_o     = leaf_q;
  assign left_present_o  = left_q;
  assign right_present_o = right_q;
  assign empty_flag_o    = empty_q;

  // every command beat gives a result beat in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result beat missing after command beat");

  // read data only shows on a successful read
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (read_value_o != '0) |-> status_o == abts_pkg::ST_OK)
    else $error("read data on a failed op");

  // a leaf has no present children
  a_leaf_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && leaf_flag_o |-> !left_present_o && !right_present_o)
    else $error("leaf flag with a present child");

  // a successful left insert shows the new child in its own result
  a_left_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == abts_pkg::OP_INS_LEFT)
    |=> (status_o != abts_pkg::ST_OK) || left_present_o)
    else $error("left insert not reflected in flags");

  // a tree-empty status goes with the empty flag
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == abts_pkg::ST_TREE_EMPTY) |-> empty_flag_o)
    else $error("tree empty status without empty flag");

endmodule

// ----- sim/abts_checker.sv -----
// result checker of the array binary tree store: watches both channels,
// keeps its own copy of the tree and compares every result beat
// depends on abts_pkg

module abts_checker
  import abts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [OpcodeW-1:0] opcode_i,
  input  logic [IndexW-1:0]  node_index_i,
  input  logic [DataW-1:0]   node_value_i,
  input  logic               done_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [DataW-1:0]   read_value_i,
  input  logic               leaf_flag_i,
  input  logic               left_present_i,
  input  logic               right_present_i,
  input  logic               empty_flag_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o,
  output logic [7:0]         status_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] value;
    logic             leaf;
    logic             left;
    logic             right;
    logic             empty;
  } tree_reply_t;

  // shadow tree
  logic [DataW-1:0] slot_value [NodeCount];
  logic             slot_used  [NodeCount];

  tree_reply_t awaited_replies [$];

  // slots past capacity never hold a node
  function automatic logic slot_taken(int unsigned slot);
    return (slot < NodeCount) && slot_used[slot];
  endfunction

  // applies one command beat to the shadow tree and returns its reply
  // a 7-bit index always lands inside the 128 slots, so only child slots
  // can fall past the end
  function automatic tree_reply_t apply_tree_op(logic [OpcodeW-1:0] op,
                                                logic [IndexW-1:0] idx,
                                                logic [DataW-1:0] val);
    tree_reply_t reply;
    int unsigned node;
    int unsigned kid;
    reply        = '0;
    reply.status = ST_OK;
    node         = idx;
    case (op)
      OP_INS_ROOT: begin
        node = 0;
        if (slot_used[0]) begin
          reply.status = ST_ROOT_EXISTS;
        end else begin
          slot_value[0] = val;
          slot_used[0]  = 1'b1;
        end
      end
      OP_INS_LEFT, OP_INS_RIGHT: begin
        kid = 2 * idx + ((op == OP_INS_LEFT) ? 1 : 2);
        // parent first, then capacity, then occupancy
        if (!slot_used[idx]) begin
          reply.status = ST_PARENT_ABSENT;
        end else if (kid >= NodeCount) begin
          reply.status = ST_OUT_OF_RANGE;
        end else if (slot_used[kid]) begin
          reply.status = ST_CHILD_EXISTS;
        end else begin
          slot_value[kid] = val;
          slot_used[kid]  = 1'b1;
        end
      end
      OP_REMOVE_LEAF: begin
        if (!slot_used[idx]) begin
          reply.status = ST_NODE_ABSENT;
        end else if (slot_taken(2 * idx + 1) || slot_taken(2 * idx + 2)) begin
          reply.status = ST_NOT_LEAF;
        end else begin
          slot_used[idx] = 1'b0;
        end
      end
      OP_READ_ROOT: begin
        node = 0;
        if (!slot_used[0]) reply.status = ST_TREE_EMPTY;
        else reply.value = slot_value[0];
      end
      OP_IS_LEAF: begin
        // no presence check on the node itself
      end
      OP_READ_NODE: begin
        if (!slot_used[idx]) reply.status = ST_NODE_ABSENT;
        else reply.value = slot_value[idx];
      end
      default: begin
        reply.status = ST_OUT_OF_RANGE;
      end
    endcase
    // flags describe the addressed node after the update
    reply.left  = slot_taken(2 * node + 1);
    reply.right = slot_taken(2 * node + 2);
    reply.leaf  = !reply.left && !reply.right;
    reply.empty = !slot_used[0];
    return reply;
  endfunction

  task automatic check_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tree_reply_t want;
    if (!rst_ni) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      awaited_replies.delete();
      fail_count_o   = 0;
      result_count_o = 0;
      status_seen_o  = '0;
    end else begin
      if (start_i && !busy_i) begin
        awaited_replies.push_back(apply_tree_op(opcode_i, node_index_i, node_value_i));
      end
      if (done_i) begin
        result_count_o++;
        if (awaited_replies.size() == 0) begin
          fail_count_o++;
          $display("%0t: result beat with nothing awaited, status %0d", $time, status_i);
        end else begin
          want = awaited_replies.pop_front();
          status_seen_o[status_i] = 1'b1;
          check_field("status", DataW'(want.status), DataW'(status_i));
          check_field("read_value", want.value, read_value_i);
          check_field("leaf_flag", DataW'(want.leaf), DataW'(leaf_flag_i));
          check_field("left_present", DataW'(want.left), DataW'(left_present_i));
          check_field("right_present", DataW'(want.right), DataW'(right_present_i));
          check_field("empty_flag", DataW'(want.empty), DataW'(empty_flag_i));
        end
      end
    end
    pending_o = awaited_replies.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// top of the array binary tree store testbench: clock, reset, command stimulus
// and verdict; depends on abts_pkg, array_binary_tree_store and abts_checker

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import abts_pkg::*;

  // opcode the block does not define; answered with out of range
  localparam logic [OpcodeW-1:0] OpUnused = 3'd7;

  // rough item budget split over the three idle profiles
  localparam int TotalCmds = 500;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start  = 1'b0;
  logic               busy;
  logic [OpcodeW-1:0] opcode_i     = '0;
  logic [IndexW-1:0]  node_index_i = '0;
  logic [DataW-1:0]   node_value_i = '0;
  logic               done_o;
  logic [StatusW-1:0] status_o;
  logic [DataW-1:0]   read_value_o;
  logic               leaf_flag_o;
  logic               left_present_o;
  logic               right_present_o;
  logic               empty_flag_o;

  int         fail_count;
  int         pending;
  int         result_count;
  logic [7:0] status_seen;

  // stimulus bookkeeping: beats sent, idle odds, position of the tree walk
  int cmds_sent = 0;
  int idle_pct  = 0;
  int walk_pos  = 0;

  always #5 clk_i = ~clk_i;

  array_binary_tree_store DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .node_index_i    (node_index_i),
    .node_value_i    (node_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .leaf_flag_o     (leaf_flag_o),
    .left_present_o  (left_present_o),
    .right_present_o (right_present_o),
    .empty_flag_o    (empty_flag_o)
  );

  abts_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .opcode_i        (opcode_i),
    .node_index_i    (node_index_i),
    .node_value_i    (node_value_i),
    .done_i          (done_o),
    .status_i        (status_o),
    .read_value_i    (read_value_o),
    .leaf_flag_i     (leaf_flag_o),
    .left_present_i  (left_present_o),
    .right_present_i (right_present_o),
    .empty_flag_i    (empty_flag_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .result_count_o  (result_count),
    .status_seen_o   (status_seen)
  );

  // one command beat; called at a rising edge, returns at the accepting edge
  // random idle cycles go in front, start stays high between back-to-back beats
  task automatic send_cmd(logic [OpcodeW-1:0] op, logic [IndexW-1:0] idx,
                          logic [DataW-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    node_index_i <= idx;
    node_value_i <= val;
    // busy read right after the edge is still the value the edge saw
    do @(posedge clk_i); while (busy);
    cmds_sent++;
  endtask

  // mostly shallow indexes, where the tree actually lives, plus the full range
  function automatic logic [IndexW-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(3);
    if (roll < 2) return IndexW'($urandom_range(14));
    if (roll == 2) return IndexW'($urandom_range(62));
    return IndexW'($urandom);
  endfunction

  // values lean on the extremes now and then
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // well-formed growth: make sure of a root, then hang children down one random
  // path; a full-depth path ends on a child slot past capacity
  task automatic grow_path();
    int  depth;
    logic go_right;
    walk_pos = 0;
    send_cmd(OP_INS_ROOT, IndexW'($urandom), pick_value());
    depth = $urandom_range(1, 7);
    repeat (depth) begin
      if (walk_pos >= NodeCount) break;
      go_right = $urandom_range(1);
      send_cmd(go_right ? OP_INS_RIGHT : OP_INS_LEFT, IndexW'(walk_pos), pick_value());
      if ($urandom_range(3) == 0) begin
        send_cmd($urandom_range(1) ? OP_IS_LEAF : OP_READ_NODE, IndexW'(walk_pos),
                 $urandom);
      end
      walk_pos = 2 * walk_pos + (go_right ? 2 : 1);
    end
  endtask

  // tear down from the end of the last walk toward the root; interior nodes
  // with another branch answer not leaf, the root going empties the tree
  task automatic prune_path();
    if (walk_pos >= NodeCount) walk_pos = (walk_pos - 1) / 2;
    do begin
      send_cmd(OP_REMOVE_LEAF, IndexW'(walk_pos), $urandom);
      if (walk_pos == 0) break;
      walk_pos = (walk_pos - 1) / 2;
    end while ($urandom_range(4) != 0);
  endtask

  // scattered single commands, the unused opcode among them
  task automatic random_noise();
    logic [OpcodeW-1:0] op;
    repeat ($urandom_range(1, 4)) begin
      op = ($urandom_range(39) == 0) ? OpUnused : OpcodeW'($urandom_range(6));
      send_cmd(op, pick_index(), pick_value());
    end
  endtask

  // directed opening: empty tree answers, error ordering, extremes of value
  // and index, and a right spine down to the last level
  task automatic run_directed();
    send_cmd(OP_READ_ROOT, '1, '1);           // read of an empty tree
    send_cmd(OP_READ_NODE, '0, '0);           // read of an absent node
    send_cmd(OP_REMOVE_LEAF, '0, '0);         // remove of an absent node
    send_cmd(OP_IS_LEAF, 7'd5, '0);           // leaf test needs no node
    send_cmd(OP_INS_LEFT, '0, '1);            // parent absent
    send_cmd(OpUnused, '1, '1);               // unused opcode
    send_cmd(OP_INS_ROOT, 7'd99, '1);
    send_cmd(OP_INS_ROOT, '0, '0);            // root already there
    send_cmd(OP_READ_ROOT, '0, '0);
    send_cmd(OP_INS_LEFT, '0, '0);
    send_cmd(OP_INS_LEFT, '0, 32'h1234_5678); // child already there
    send_cmd(OP_INS_RIGHT, '0, 32'hA5A5_5A5A);
    send_cmd(OP_IS_LEAF, '0, '0);
    send_cmd(OP_REMOVE_LEAF, '0, '0);         // root is not a leaf
    send_cmd(OP_READ_NODE, 7'd2, '0);
    send_cmd(OP_INS_RIGHT, 7'd2, 32'h8000_0001);
    send_cmd(OP_INS_RIGHT, 7'd6, 32'h0000_FFFF);
    send_cmd(OP_INS_RIGHT, 7'd14, 32'hFFFF_0000);
    send_cmd(OP_INS_RIGHT, 7'd30, 32'h7FFF_FFFF);
    send_cmd(OP_INS_RIGHT, 7'd62, 32'hDEAD_BEEF);
    send_cmd(OP_INS_LEFT, 7'd126, '1);        // child slot past capacity
    send_cmd(OP_INS_RIGHT, '1, '1);           // top index, parent absent
    send_cmd(OP_READ_NODE, 7'd126, '0);
    send_cmd(OP_REMOVE_LEAF, 7'd126, '0);
    send_cmd(OpUnused, '0, '0);               // unused opcode on the root's flags
  endtask

  initial begin
    int idle_by_phase [3];
    int roll;
    idle_by_phase = '{13, 73, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = idle_by_phase[ph];
      if (ph == 0) run_directed();
      while (cmds_sent < (ph + 1) * TotalCmds / 3) begin
        roll = $urandom_range(99);
        if (roll < 45) grow_path();
        else if (roll < 75) prune_path();
        else random_noise();
      end
    end
    start <= 1'b0;

    // drain, sampling away from the active edge
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("run covered %0d command beats over three idle profiles, %0d result beats",
             cmds_sent, result_count);
    $display("status codes returned, one bit per code: %b", status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #1ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
